// ----- rtl/psj3_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// psj3_pkg
// Types and constants shared by the Jacobi principal stress core.
// ----------------------------------------------------------------------------
package psj3_pkg;

    localparam int unsigned TOL_W = 31;
    localparam int unsigned ROT_W = 7;
    localparam int unsigned CFG_W = 31;
    localparam int unsigned MAT_W = 35;

    localparam logic [TOL_W-1:0] TOL_RESET = 31'd66;
    localparam logic [ROT_W-1:0] MAXROT_RESET = 7'd7;

    localparam logic CFG_TOLERANCE = 1'b0;
    localparam logic CFG_MAX_ROTATIONS = 1'b1;

    localparam logic signed [MAT_W-1:0] MAT_LIM = 35'sh3_FFFF_FFFF;
    localparam logic signed [MAT_W-1:0] ROT_LIM = 35'sh0_7FFF_FFFF;
    localparam logic signed [MAT_W-1:0] ONE_Q30 = 35'sh0_4000_0000;

    typedef struct packed {
        logic signed [31:0] stress_xx;
        logic signed [31:0] stress_yy;
        logic signed [31:0] stress_zz;
        logic signed [31:0] stress_xy;
        logic signed [31:0] stress_yz;
        logic signed [31:0] stress_zx;
    } in_word_t;

    typedef struct packed {
        logic [1:0]         axis_index;
        logic signed [31:0] principal_stress;
        logic signed [31:0] rot_col0;
        logic signed [31:0] rot_col1;
        logic signed [31:0] rot_col2;
        logic               converged;
        logic               last_of_run;
    } out_word_t;

endpackage : psj3_pkg
`default_nettype wire

// ----- rtl/principal_stress_jacobi_3x3_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// principal_stress_jacobi_3x3_core
// Jacobi diagonalization of a symmetric 3x3 tensor on a shared sequencer.
// ----------------------------------------------------------------------------
// A rotation runs four 32-step square roots, two 64-step divisions (one when
//   the radius is zero) and 24 products through one shared multiplier.
// A new tensor is taken only in S_IDLE; in_stall is high until all three words
//   of the previous tensor have been taken.
// Reset clears control state and loads the register resets.
module principal_stress_jacobi_3x3_core (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_stall,
    input  wire psj3_pkg::in_word_t in_data,
    output logic                out_valid,
    input  wire                 out_stall,
    output psj3_pkg::out_word_t out_data,
    input  wire                 cfg_we,
    input  wire [0:0]           cfg_index,
    input  wire [psj3_pkg::CFG_W-1:0] cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE, S_PIVOT, S_SHIFT, S_SQ1, S_ROOT1, S_DIV1, S_SQ2, S_ROOT2, S_DEN,
        S_ROOT3, S_DIV2, S_SQ3, S_ROOT4, S_CS, S_MUL, S_OUT
    } state_t;

    typedef logic signed [psj3_pkg::MAT_W-1:0] mval_t;

    state_t state_reg;
    logic [psj3_pkg::TOL_W-1:0] tol_reg;
    logic [psj3_pkg::ROT_W-1:0] maxrot_reg, done_reg;
    mval_t m_reg [6];   // 0:xx 1:yy 2:zz 3:xy 4:yz 5:zx
    mval_t v_reg [9];
    logic [1:0] p_reg, q_reg, k_reg;
    logic conv_reg, oneg_reg;
    logic [63:0] ux_reg, ud_reg, acc_reg;
    logic [63:0] sq_v_reg, sq_res_reg, sq_bit_reg;
    logic [63:0] dv_num_reg;
    logic [63:0] dv_den_reg, dv_rem_reg, dv_q_reg;
    logic [6:0] cnt_reg;
    logic [63:0] om_reg, sn_reg, cn_reg, cn2_reg, sn2_reg;
    logic [4:0] mstep_reg;
    mval_t t0_reg, t1_reg, t2_reg;

    // Index of symmetric entry (i,j).
    function automatic logic [2:0] ent(input logic [1:0] i, input logic [1:0] j);
        logic [2:0] r;
        begin
            if (i == j) r = {1'b0, i};
            else if ((i == 2'd0 && j == 2'd1) || (i == 2'd1 && j == 2'd0)) r = 3'd3;
            else if ((i == 2'd1 && j == 2'd2) || (i == 2'd2 && j == 2'd1)) r = 3'd4;
            else r = 3'd5;
            return r;
        end
    endfunction

    // Index of rotation matrix entry (row, col).
    function automatic logic [3:0] vidx(input logic [1:0] row, input logic [1:0] col);
        return 4'(row) * 4'd3 + 4'(col);
    endfunction

    function automatic logic [63:0] magv(input mval_t a);
        return a[psj3_pkg::MAT_W-1] ? 64'(-a) : 64'(a);
    endfunction

    function automatic mval_t sat(input logic signed [39:0] x, input mval_t lim);
        if (x > 40'(lim)) return lim;
        else if (x < -40'(lim)) return -lim;
        else return x[psj3_pkg::MAT_W-1:0];
    endfunction

    // Shared rounded multiplier: a * b / 2^30, half away from zero.
    // The second operand is always a Q2.30 factor of magnitude at most 2^30.
    mval_t mul_a, mul_b, mul_y;
    logic [63:0] mul_ma, mul_mb;
    logic [67:0] mul_p;
    always_comb
    begin
        mul_ma = magv(mul_a);
        mul_mb = magv(mul_b);
        mul_p  = 68'(mul_ma[33:0]) * 68'(mul_mb[30:0]) + 68'(64'h2000_0000);
        mul_y  = mval_t'(mul_p[64:30]);
        if (mul_a[psj3_pkg::MAT_W-1] != mul_b[psj3_pkg::MAT_W-1])
            mul_y = -mul_y;
    end

    // Shared squarer for the radius and the two cosine square roots.
    logic [30:0] sqr_in;
    logic [61:0] sqr_out;
    always_comb
    begin
        unique case (state_reg)
            S_SHIFT: sqr_in = ux_reg[30:0];
            S_SQ1:   sqr_in = ud_reg[30:0];
            S_SQ2:   sqr_in = om_reg[30:0];
            S_SQ3:   sqr_in = sn_reg[30:0];
            default: sqr_in = '0;
        endcase
    end
    assign sqr_out = 62'(sqr_in) * 62'(sqr_in);

    // Multiply schedule: operands and accumulation per step.
    logic [1:0] r_idx;
    mval_t omg, snv, cnv;
    logic [1:0] vi;
    assign r_idx = 2'd3 - p_reg - q_reg;
    assign omg = oneg_reg ? -mval_t'(om_reg) : mval_t'(om_reg);
    assign snv = oneg_reg ? -mval_t'(sn_reg) : mval_t'(sn_reg);
    assign cnv = mval_t'(cn_reg);
    assign vi = 2'(mstep_reg >> 2);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_CS)
        begin
            mul_a = mstep_reg[0] ? snv : cnv;
            mul_b = mstep_reg[0] ? snv : cnv;
        end
        else
        begin
            case (mstep_reg)
                5'd0:  begin mul_a = m_reg[ent(p_reg,p_reg)]; mul_b = mval_t'(cn2_reg); end
                5'd1:  begin mul_a = m_reg[ent(q_reg,q_reg)]; mul_b = mval_t'(sn2_reg); end
                5'd2:  begin mul_a = m_reg[ent(p_reg,q_reg)]; mul_b = omg; end
                5'd3:  begin mul_a = m_reg[ent(p_reg,p_reg)]; mul_b = mval_t'(sn2_reg); end
                5'd4:  begin mul_a = m_reg[ent(q_reg,q_reg)]; mul_b = mval_t'(cn2_reg); end
                5'd5:  begin mul_a = m_reg[ent(p_reg,q_reg)]; mul_b = omg; end
                5'd6:  begin mul_a = m_reg[ent(p_reg,r_idx)]; mul_b = cnv; end
                5'd7:  begin mul_a = m_reg[ent(q_reg,r_idx)]; mul_b = snv; end
                5'd8:  begin mul_a = m_reg[ent(q_reg,r_idx)]; mul_b = cnv; end
                5'd9:  begin mul_a = m_reg[ent(p_reg,r_idx)]; mul_b = snv; end
                default:
                begin
                    // steps 12..23: row vi - 3 (wrapping), four products each
                    case (mstep_reg[1:0])
                        2'd0: begin mul_a = v_reg[vidx(vi-2'd3, p_reg)]; mul_b = cnv; end
                        2'd1: begin mul_a = v_reg[vidx(vi-2'd3, q_reg)]; mul_b = snv; end
                        2'd2: begin mul_a = v_reg[vidx(vi-2'd3, q_reg)]; mul_b = cnv; end
                        default: begin mul_a = v_reg[vidx(vi-2'd3, p_reg)]; mul_b = snv; end
                    endcase
                end
            endcase
        end
    end

    // Pivot search.
    logic [63:0] f01, f02, f12, fm;
    logic [1:0] pp, pq;
    always_comb
    begin
        f01 = magv(m_reg[3]);
        f02 = magv(m_reg[5]);
        f12 = magv(m_reg[4]);
        fm = f01; pp = 2'd0; pq = 2'd1;
        if (f02 > fm) begin fm = f02; pq = 2'd2; end
        if (f12 > fm) begin fm = f12; pp = 2'd1; pq = 2'd2; end
    end

    // Square root step and rounding.
    logic [63:0] sq_t, sq_round;
    assign sq_t = sq_res_reg + sq_bit_reg;
    assign sq_round = (sq_v_reg > sq_res_reg) ? sq_res_reg + 64'd1 : sq_res_reg;

    // Divider: one quotient bit per cycle (restoring).
    logic [64:0] dv_trial;
    assign dv_trial = {dv_rem_reg, dv_num_reg[63]} - {1'b0, dv_den_reg};

    logic        go;
    assign go = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);

    // The difference of two diagonal entries needs one bit more than an entry.
    mval_t app_d, aqq_d, apq_d;
    logic signed [psj3_pkg::MAT_W:0] dif;
    assign app_d = m_reg[ent(p_reg,p_reg)];
    assign aqq_d = m_reg[ent(q_reg,q_reg)];
    assign apq_d = m_reg[ent(p_reg,q_reg)];
    assign dif = {aqq_d[psj3_pkg::MAT_W-1], aqq_d} - {app_d[psj3_pkg::MAT_W-1], app_d};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            tol_reg    <= psj3_pkg::TOL_RESET;
            maxrot_reg <= psj3_pkg::MAXROT_RESET;
            out_valid  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    psj3_pkg::CFG_TOLERANCE:     tol_reg <= cfg_data;
                    psj3_pkg::CFG_MAX_ROTATIONS: maxrot_reg <= cfg_data[psj3_pkg::ROT_W-1:0];
                    default: ;
                endcase
            end
            unique case (state_reg) inside
                S_IDLE:
                begin
                    if (go)
                    begin
                        m_reg[0] <= mval_t'(in_data.stress_xx);
                        m_reg[1] <= mval_t'(in_data.stress_yy);
                        m_reg[2] <= mval_t'(in_data.stress_zz);
                        m_reg[3] <= mval_t'(in_data.stress_xy);
                        m_reg[4] <= mval_t'(in_data.stress_yz);
                        m_reg[5] <= mval_t'(in_data.stress_zx);
                        for (int i = 0; i < 9; i++)
                            v_reg[i] <= (i % 4 == 0) ? psj3_pkg::ONE_Q30 : '0;
                        done_reg  <= '0;
                        state_reg <= S_PIVOT;
                    end
                end
                S_PIVOT:
                begin
                    p_reg <= pp;
                    q_reg <= pq;
                    if (fm < 64'(tol_reg))
                    begin
                        conv_reg <= 1'b1; k_reg <= 2'd0; state_reg <= S_OUT;
                    end
                    else if (done_reg >= maxrot_reg)
                    begin
                        conv_reg <= 1'b0; k_reg <= 2'd0; state_reg <= S_OUT;
                    end
                    else
                    begin
                        done_reg <= done_reg + 1'b1;
                        state_reg <= S_SHIFT;
                        cnt_reg <= '0;
                    end
                end
                S_SHIFT:
                begin
                    if (cnt_reg == 7'd0)
                    begin
                        ux_reg <= magv(apq_d) << 1;
                        ud_reg <= dif[psj3_pkg::MAT_W] ? 64'(-dif) : 64'(dif);
                        oneg_reg <= (apq_d > 0) != dif[psj3_pkg::MAT_W];
                        cnt_reg <= 7'd1;
                    end
                    else if (ux_reg >= 64'h8000_0000 || ud_reg >= 64'h8000_0000)
                    begin
                        ux_reg <= ux_reg >> 1;
                        ud_reg <= ud_reg >> 1;
                    end
                    else
                    begin
                        acc_reg <= 64'(sqr_out);
                        state_reg <= S_SQ1;
                    end
                end
                S_SQ1:
                begin
                    sq_v_reg <= acc_reg + 64'(sqr_out);
                    sq_res_reg <= '0; sq_bit_reg <= 64'h4000_0000_0000_0000;
                    cnt_reg <= 7'd0;
                    state_reg <= S_ROOT1;
                end
                S_ROOT1, S_ROOT2, S_ROOT3, S_ROOT4:
                begin
                    if (sq_bit_reg != 0)
                    begin
                        if (sq_v_reg >= sq_t)
                        begin
                            sq_v_reg <= sq_v_reg - sq_t;
                            sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                        end
                        else sq_res_reg <= sq_res_reg >> 1;
                        sq_bit_reg <= sq_bit_reg >> 2;
                    end
                    else if (state_reg == S_ROOT1)
                    begin
                        if (sq_round == 0)
                        begin
                            om_reg <= '0; state_reg <= S_SQ2;
                        end
                        else
                        begin
                            dv_num_reg <= (ux_reg << 30) + (sq_round >> 1);
                            dv_den_reg <= sq_round; dv_rem_reg <= '0; dv_q_reg <= '0;
                            cnt_reg <= '0; state_reg <= S_DIV1;
                        end
                    end
                    else if (state_reg == S_ROOT2)
                    begin
                        acc_reg <= 64'(2) * (64'h4000_0000 + sq_round);
                        state_reg <= S_DEN;
                    end
                    else if (state_reg == S_ROOT3)
                    begin
                        dv_num_reg <= (om_reg << 30) + (sq_round >> 1);
                        dv_den_reg <= sq_round; dv_rem_reg <= '0; dv_q_reg <= '0;
                        cnt_reg <= '0; state_reg <= S_DIV2;
                    end
                    else
                    begin
                        cn_reg <= sq_round; mstep_reg <= '0; state_reg <= S_CS;
                    end
                end
                S_DIV1, S_DIV2:
                begin
                    if (cnt_reg == 7'd64)
                    begin
                        if (state_reg == S_DIV1)
                        begin
                            om_reg <= (dv_q_reg > 64'h4000_0000) ? 64'h4000_0000 : dv_q_reg;
                            state_reg <= S_SQ2;
                        end
                        else
                        begin
                            sn_reg <= dv_q_reg; state_reg <= S_SQ3;
                        end
                    end
                    else
                    begin
                        // The numerator stays below 2^62, so 64 steps cover it.
                        if (!dv_trial[64])
                        begin
                            dv_rem_reg <= dv_trial[63:0];
                            dv_q_reg <= {dv_q_reg[62:0], 1'b1};
                        end
                        else
                        begin
                            dv_rem_reg <= {dv_rem_reg[62:0], dv_num_reg[63]};
                            dv_q_reg <= {dv_q_reg[62:0], 1'b0};
                        end
                        dv_num_reg <= dv_num_reg << 1;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_SQ2:
                begin
                    sq_v_reg <= 64'h1000_0000_0000_0000 - 64'(sqr_out);
                    sq_res_reg <= '0; sq_bit_reg <= 64'h4000_0000_0000_0000;
                    state_reg <= S_ROOT2;
                end
                S_DEN:
                begin
                    sq_v_reg <= acc_reg << 30;
                    sq_res_reg <= '0; sq_bit_reg <= 64'h4000_0000_0000_0000;
                    state_reg <= S_ROOT3;
                end
                S_SQ3:
                begin
                    sq_v_reg <= 64'h1000_0000_0000_0000 - 64'(sqr_out);
                    sq_res_reg <= '0; sq_bit_reg <= 64'h4000_0000_0000_0000;
                    state_reg <= S_ROOT4;
                end
                S_CS:
                begin
                    if (mstep_reg[0])
                    begin
                        sn2_reg <= 64'(mul_y); mstep_reg <= '0; state_reg <= S_MUL;
                    end
                    else
                    begin
                        cn2_reg <= 64'(mul_y); mstep_reg <= 5'd1;
                    end
                end
                S_MUL:
                begin
                    case (mstep_reg) inside
                        5'd0, 5'd3, 5'd6, 5'd8: t0_reg <= mul_y;
                        5'd1, 5'd4: t1_reg <= mul_y;
                        5'd2: t2_reg <= sat(40'(t0_reg) + 40'(t1_reg) + 40'(mul_y),
                                            psj3_pkg::MAT_LIM);
                        5'd5:
                        begin
                            m_reg[ent(q_reg,q_reg)] <= sat(40'(t0_reg) + 40'(t1_reg)
                                - 40'(mul_y), psj3_pkg::MAT_LIM);
                            m_reg[ent(p_reg,p_reg)] <= t2_reg;
                            m_reg[ent(p_reg,q_reg)] <= '0;
                        end
                        5'd7: t1_reg <= sat(40'(t0_reg) + 40'(mul_y), psj3_pkg::MAT_LIM);
                        5'd9:
                        begin
                            m_reg[ent(q_reg,r_idx)] <= sat(40'(t0_reg) - 40'(mul_y),
                                                           psj3_pkg::MAT_LIM);
                            m_reg[ent(p_reg,r_idx)] <= t1_reg;
                        end
                        default:
                        begin
                            case (mstep_reg[1:0]) inside
                                2'd0, 2'd2: t0_reg <= mul_y;
                                2'd1: t1_reg <= sat(40'(t0_reg) + 40'(mul_y),
                                                    psj3_pkg::ROT_LIM);
                                default:
                                begin
                                    v_reg[vidx(vi-2'd3, q_reg)] <= sat(40'(t0_reg)
                                        - 40'(mul_y), psj3_pkg::ROT_LIM);
                                    v_reg[vidx(vi-2'd3, p_reg)] <= t1_reg;
                                end
                            endcase
                        end
                    endcase
                    if (mstep_reg == 5'd9) mstep_reg <= 5'd12;
                    else if (mstep_reg == 5'd23) state_reg <= S_PIVOT;
                    else mstep_reg <= mstep_reg + 1'b1;
                end
                S_OUT:
                begin
                    if (!out_valid || !out_stall)
                    begin
                        if (k_reg == 2'd3)
                        begin
                            out_valid <= 1'b0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            out_valid <= 1'b1;
                            out_data.axis_index <= k_reg;
                            out_data.principal_stress <=
                                (m_reg[ent(k_reg,k_reg)] > 35'sh0_7FFF_FFFF)
                                ? 32'sh7FFF_FFFF
                                : (m_reg[ent(k_reg,k_reg)] < -35'sh0_8000_0000)
                                ? 32'sh8000_0000 : m_reg[ent(k_reg,k_reg)][31:0];
                            out_data.rot_col0 <= v_reg[vidx(k_reg, 2'd0)][31:0];
                            out_data.rot_col1 <= v_reg[vidx(k_reg, 2'd1)][31:0];
                            out_data.rot_col2 <= v_reg[vidx(k_reg, 2'd2)][31:0];
                            out_data.converged <= conv_reg;
                            out_data.last_of_run <= (k_reg == 2'd2);
                            k_reg <= k_reg + 1'b1;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule : principal_stress_jacobi_3x3_core
`default_nettype wire

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Jacobi principal stress core. Tensors are sent
// over the input channel while both channels idle and stall at random. A
// fixed-point model of the rotation loop predicts the three words of each
// tensor. Every word that is taken is compared field by field, in order.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned CYCLE_LIMIT = 64'd6_000_000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    psj3_pkg::in_word_t  in_data;
    logic      out_valid;
    logic      out_stall;
    psj3_pkg::out_word_t out_data;
    logic      cfg_we;
    logic [0:0] cfg_index;
    logic [psj3_pkg::CFG_W-1:0] cfg_data;

    principal_stress_jacobi_3x3_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    psj3_pkg::out_word_t pending_words[$];
    int unsigned      error_count = 0;
    longint unsigned  cycle_count = 0;
    bit               calm = 0;
    longint unsigned  tol_setting;
    longint unsigned  rot_limit;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic report(input string what, input longint got, input longint want);
        error_count++;
        $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got,
                 want);
    endtask

    // ---------------- fixed-point Jacobi predictor ----------------

    function automatic longint unsigned magnitude(input longint a);
        return (a < 0) ? longint'(-a) : a;
    endfunction

    function automatic longint clip(input longint x, input longint lo, input longint hi);
        return (x > hi) ? hi : ((x < lo) ? lo : x);
    endfunction

    // Product with a Q2.30 factor, rounded half away from zero.
    function automatic longint mul_q30(input longint a, input longint b);
        bit neg;
        longint unsigned p;
        neg = (a < 0) != (b < 0);
        p = ((magnitude(a) * magnitude(b)) + (64'd1 << 29)) >> 30;
        return neg ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint unsigned sqrt_round(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
            begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return (v > res) ? res + 1 : res;
    endfunction

    function automatic longint unsigned div_round(input longint unsigned num,
                                                   input longint unsigned den);
        return (num + den / 2) / den;
    endfunction

    task automatic predict_axes(input psj3_pkg::in_word_t w);
        longint mm[3][3];
        longint vv[3][3];
        longint unsigned done;
        longint unsigned fm, ux, ud, rad, om, s1, den, dd, snm;
        longint app, aqq, apq, dif, sn, omg, cn, cn2, sn2, fp, fq, vp, vq;
        longint one, mlim, rlim;
        bit conv, oneg;
        int p, q, r;
        psj3_pkg::out_word_t o;
        one = 64'sd1 << 30;
        mlim = (64'sd1 << 34) - 1;
        rlim = (64'sd1 << 31) - 1;
        mm[0][0] = w.stress_xx;
        mm[1][1] = w.stress_yy;
        mm[2][2] = w.stress_zz;
        mm[0][1] = w.stress_xy;
        mm[1][0] = w.stress_xy;
        mm[1][2] = w.stress_yz;
        mm[2][1] = w.stress_yz;
        mm[0][2] = w.stress_zx;
        mm[2][0] = w.stress_zx;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                vv[i][j] = (i == j) ? one : 0;
        done = 0;
        while (1)
        begin
            p = 0;
            q = 1;
            fm = magnitude(mm[0][1]);
            if (magnitude(mm[0][2]) > fm)
            begin
                fm = magnitude(mm[0][2]);
                q = 2;
            end
            if (magnitude(mm[1][2]) > fm)
            begin
                fm = magnitude(mm[1][2]);
                p = 1;
                q = 2;
            end
            if (fm < tol_setting)
            begin
                conv = 1;
                break;
            end
            if (done >= rot_limit)
            begin
                conv = 0;
                break;
            end
            done++;
            r = 3 - p - q;
            app = mm[p][p];
            aqq = mm[q][q];
            apq = mm[p][q];
            dif = aqq - app;
            ux = 2 * magnitude(apq);
            ud = magnitude(dif);
            om = 0;
            oneg = (apq > 0) != (dif < 0);
            while (ux >= (64'd1 << 31) || ud >= (64'd1 << 31))
            begin
                ux >>= 1;
                ud >>= 1;
            end
            rad = sqrt_round(ux * ux + ud * ud);
            if (rad != 0)
            begin
                om = div_round(ux << 30, rad);
                if (om > (64'd1 << 30))
                    om = 64'd1 << 30;
            end
            s1 = sqrt_round((64'd1 << 60) - om * om);
            den = 2 * ((64'd1 << 30) + s1);
            dd = sqrt_round(den << 30);
            snm = div_round(om << 30, dd);
            sn = oneg ? -longint'(snm) : longint'(snm);
            omg = oneg ? -longint'(om) : longint'(om);
            cn = longint'(sqrt_round((64'd1 << 60) - snm * snm));
            cn2 = mul_q30(cn, cn);
            sn2 = mul_q30(sn, sn);
            mm[p][p] = clip(mul_q30(app, cn2) + mul_q30(aqq, sn2) + mul_q30(apq, omg),
                            -mlim, mlim);
            mm[q][q] = clip(mul_q30(app, sn2) + mul_q30(aqq, cn2) - mul_q30(apq, omg),
                            -mlim, mlim);
            mm[p][q] = 0;
            mm[q][p] = 0;
            fp = mm[p][r];
            fq = mm[q][r];
            mm[p][r] = clip(mul_q30(fp, cn) + mul_q30(fq, sn), -mlim, mlim);
            mm[r][p] = mm[p][r];
            mm[q][r] = clip(mul_q30(fq, cn) - mul_q30(fp, sn), -mlim, mlim);
            mm[r][q] = mm[q][r];
            for (int i = 0; i < 3; i++)
            begin
                vp = vv[i][p];
                vq = vv[i][q];
                vv[i][p] = clip(mul_q30(vp, cn) + mul_q30(vq, sn), -rlim, rlim);
                vv[i][q] = clip(mul_q30(vq, cn) - mul_q30(vp, sn), -rlim, rlim);
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            o.axis_index       = k[1:0];
            o.principal_stress = 32'(clip(mm[k][k], -(64'sd1 << 31), (64'sd1 << 31) - 1));
            o.rot_col0         = vv[k][0][31:0];
            o.rot_col1         = vv[k][1][31:0];
            o.rot_col2         = vv[k][2][31:0];
            o.converged        = conv;
            o.last_of_run      = (k == 2);
            pending_words.push_back(o);
        end
    endtask

    // ---------------- result checking and output stalls ----------------

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_words.size() == 0)
            begin
                report("unexpected word", out_data.axis_index, 0);
            end
            else
            begin
                psj3_pkg::out_word_t e;
                e = pending_words.pop_front();
                if (out_data.axis_index != e.axis_index)
                    report("axis_index", out_data.axis_index, e.axis_index);
                if (out_data.principal_stress != e.principal_stress)
                    report("principal_stress", out_data.principal_stress,
                           e.principal_stress);
                if (out_data.rot_col0 != e.rot_col0)
                    report("rot_col0", out_data.rot_col0, e.rot_col0);
                if (out_data.rot_col1 != e.rot_col1)
                    report("rot_col1", out_data.rot_col1, e.rot_col1);
                if (out_data.rot_col2 != e.rot_col2)
                    report("rot_col2", out_data.rot_col2, e.rot_col2);
                if (out_data.converged != e.converged)
                    report("converged", out_data.converged, e.converged);
                if (out_data.last_of_run != e.last_of_run)
                    report("last_of_run", out_data.last_of_run, e.last_of_run);
            end
        end
    end

    always @(negedge clk)
    begin
        out_stall <= !calm && ($urandom_range(99) < 21);
    end

    // ---------------- stimulus helpers ----------------

    // Returns at the falling edge after acceptance with in_valid still high;
    // the caller sends the next tensor or drops valid at that same edge.
    task automatic send_tensor(input psj3_pkg::in_word_t w);
        predict_axes(w);
        while (!calm && $urandom_range(99) < 21)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_data  <= w;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [psj3_pkg::CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == psj3_pkg::CFG_TOLERANCE)
            tol_setting = value;
        else
            rot_limit = value[psj3_pkg::ROT_W-1:0];
    endtask

    task automatic set_regs(input logic [psj3_pkg::CFG_W-1:0] tol,
                            input logic [psj3_pkg::CFG_W-1:0] rots);
        drain();
        write_reg(psj3_pkg::CFG_TOLERANCE, tol);
        write_reg(psj3_pkg::CFG_MAX_ROTATIONS, rots);
    endtask

    function automatic psj3_pkg::in_word_t make_tensor(input logic [31:0] xx,
                                                       input logic [31:0] yy,
                                                       input logic [31:0] zz,
                                                       input logic [31:0] xy,
                                                       input logic [31:0] yz,
                                                       input logic [31:0] zx);
        psj3_pkg::in_word_t w;
        w.stress_xx = xx;
        w.stress_yy = yy;
        w.stress_zz = zz;
        w.stress_xy = xy;
        w.stress_yz = yz;
        w.stress_zx = zx;
        return w;
    endfunction

    function automatic logic [31:0] random_stress(input int shape);
        logic [31:0] v;
        v = $urandom;
        case (shape)
            0: return v;
            1: return {{12{v[19]}}, v[19:0]};
            2: return {{20{v[11]}}, v[11:0]};
            default: return ($urandom_range(1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    function automatic psj3_pkg::in_word_t random_tensor();
        int shape;
        int r;
        r = $urandom_range(99);
        shape = (r < 30) ? 0 : (r < 65) ? 1 : (r < 95) ? 2 : 3;
        return make_tensor(random_stress(shape), random_stress(shape),
                           random_stress(shape), random_stress(shape),
                           random_stress(shape), random_stress(shape));
    endfunction

    // ---------------- tests ----------------

    task automatic test_directed();
        set_regs(psj3_pkg::TOL_RESET, psj3_pkg::CFG_W'(psj3_pkg::MAXROT_RESET));
        send_tensor(make_tensor(0, 0, 0, 0, 0, 0));
        send_tensor(make_tensor(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0, 0, 0));
        send_tensor(make_tensor(32'h0001_0000, 32'h0001_0000, 0, 32'h0000_8000, 0, 0));
        send_tensor(make_tensor(0, 0, 0, 32'hFFFF_0000, 0, 0));
        send_tensor(make_tensor(0, 0, 0, 0, 32'h0004_0000, 0));
        send_tensor(make_tensor(0, 0, 0, 0, 0, 32'hFFFC_0000));
        // Equal shear magnitudes: the first in row-major order is the pivot.
        send_tensor(make_tensor(32'h0001_0000, 32'hFFFF_0000, 0, 32'h0002_0000,
                                32'h0002_0000, 32'hFFFE_0000));
        send_tensor(make_tensor(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_tensor(make_tensor(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_tensor(make_tensor(32'h8000_0000, 32'h7FFF_FFFF, 0,
                                32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
        send_tensor(make_tensor(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                                32'hFFFF_FFFF, 32'h0000_0041, 32'h0000_0042));
        send_tensor(make_tensor(32'h0010_0000, 32'h0010_0000, 32'h0010_0000,
                                32'h0000_0042, 32'hFFFF_FFBE, 32'h0000_0041));
    endtask

    task automatic test_zero_tolerance();
        // Never converges; an all-zero tensor hits the zero-radius rotation.
        set_regs(0, 3);
        send_tensor(make_tensor(0, 0, 0, 0, 0, 0));
        send_tensor(make_tensor(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0, 0, 0));
        send_tensor(make_tensor(32'h0003_0000, 32'h0001_0000, 0, 32'h0000_1000,
                                32'h0000_0200, 32'h0000_0030));
    endtask

    task automatic test_zero_limit();
        set_regs(psj3_pkg::TOL_RESET, 0);
        send_tensor(make_tensor(32'h0001_0000, 0, 0, 32'h0000_0010, 0, 0));
        send_tensor(make_tensor(32'h0001_0000, 0, 0, 32'h0001_0000, 0, 0));
    endtask

    task automatic test_register_extremes();
        // Only the low seven bits of the limit are kept.
        set_regs(31'h7FFF_FFFF, 31'h7FFF_FF80);
        send_tensor(random_tensor());
        send_tensor(make_tensor(0, 0, 0, 32'h8000_0000, 0, 0));
        set_regs(1, 127);
        send_tensor(make_tensor(32'h0005_0000, 32'hFFFB_0000, 32'h0002_0000,
                                32'h0003_0000, 32'h0001_8000, 32'hFFFE_4000));
        set_regs(1, 64);
        send_tensor(random_tensor());
        send_tensor(random_tensor());
    endtask

    task automatic test_random(input int count, input bit quiet_phase);
        set_regs(psj3_pkg::TOL_RESET, psj3_pkg::CFG_W'(psj3_pkg::MAXROT_RESET));
        calm = quiet_phase;
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 39)
            begin
                if ($urandom_range(3) == 0)
                    set_regs(psj3_pkg::CFG_W'($urandom_range(1, 31'h7FFF_FFFF)),
                             psj3_pkg::CFG_W'($urandom_range(1, 7)));
                else
                    set_regs(psj3_pkg::CFG_W'($urandom_range(1, 4096)),
                             psj3_pkg::CFG_W'($urandom_range(1, 10)));
            end
            send_tensor(random_tensor());
        end
        drain();
        calm = 1'b0;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_stall = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = psj3_pkg::CFG_TOLERANCE;
        cfg_data  = '0;
        tol_setting = psj3_pkg::TOL_RESET;
        rot_limit   = psj3_pkg::MAXROT_RESET;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_zero_tolerance();
        test_zero_limit();
        test_register_extremes();
        test_random(300, 1'b0);
        test_random(80, 1'b1);
        drain();
        repeat (50) @(negedge clk);

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
